[rtl/out_of_order_segment_reassembly_assert.svh]
// Assertion macros for the segment reassembly block.
// Used by out_of_order_segment_reassembly.sv; needs a clock and an active-low reset.
`ifndef OUT_OF_ORDER_SEGMENT_REASSEMBLY_ASSERT_SVH
`define OUT_OF_ORDER_SEGMENT_REASSEMBLY_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define OOSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("oosr: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define OOSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("oosr: next-cycle check failed");

`endif

[rtl/oosr_pkg.sv]
// Shared types, codes and helpers for the segment reassembly block.
// No dependencies.
`default_nettype none

package oosr_pkg;

    localparam int unsigned SEQ_BITS    = 32;
    localparam int unsigned LEN_BITS    = 16;
    localparam int unsigned ROOM_BITS   = 16;
    localparam int unsigned STATUS_BITS = 3;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_EMPTY     = 3'd0,
        ST_GAP       = 3'd1,
        ST_BUF_FULL  = 3'd2,
        ST_STALE     = 3'd3,
        ST_DROPPED   = 3'd4
    } t_status;

    typedef enum logic {
        KIND_RELEASE = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

    // Wrap-around order: a precedes b when a - b has bit 31 set.
    function automatic logic seq_before(input logic [SEQ_BITS-1:0] a,
                                        input logic [SEQ_BITS-1:0] b);
        logic [SEQ_BITS-1:0] d;
        d = a - b;
        return d[SEQ_BITS-1];
    endfunction

endpackage

`default_nettype wire

[rtl/oosr_cell.sv]
// One slot of the sorted segment chain: holds one entry and shifts with its neighbors.
// Depends on oosr_pkg.
`default_nettype none

module oosr_cell #(
    parameter int unsigned TAG_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  oosr_pkg::t_cell_ctrl       i_ctrl,
    input  wire  [oosr_pkg::SEQ_BITS-1:0]    i_new_seq,
    input  wire  [oosr_pkg::LEN_BITS-1:0]    i_new_len,
    input  wire  [TAG_BITS-1:0]              i_new_tag,
    input  wire                              i_left_valid,
    input  wire                              i_left_prefix,
    input  wire  [oosr_pkg::SEQ_BITS-1:0]    i_left_seq,
    input  wire  [oosr_pkg::LEN_BITS-1:0]    i_left_len,
    input  wire  [TAG_BITS-1:0]              i_left_tag,
    input  wire                              i_right_valid,
    input  wire  [oosr_pkg::SEQ_BITS-1:0]    i_right_seq,
    input  wire  [oosr_pkg::LEN_BITS-1:0]    i_right_len,
    input  wire  [TAG_BITS-1:0]              i_right_tag,
    output logic                             o_valid,
    output logic                             o_prefix,
    output logic [oosr_pkg::SEQ_BITS-1:0]    o_seq,
    output logic [oosr_pkg::LEN_BITS-1:0]    o_len,
    output logic [TAG_BITS-1:0]              o_tag
);

    logic                          r_valid;
    logic [oosr_pkg::SEQ_BITS-1:0] r_seq;
    logic [oosr_pkg::LEN_BITS-1:0] r_len;
    logic [TAG_BITS-1:0]           r_tag;

    logic w_hit;
    logic w_slot_free;

    assign w_hit       = r_valid && oosr_pkg::seq_before(i_new_seq, r_seq);
    assign w_slot_free = !r_valid && i_left_valid;
    assign o_prefix    = i_left_prefix || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.pop) begin
            r_valid <= i_right_valid;
        end else if (i_ctrl.ins) begin
            if (i_left_prefix) begin
                r_valid <= i_left_valid;
            end else if (w_hit || w_slot_free) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_seq <= i_right_seq;
            r_len <= i_right_len;
            r_tag <= i_right_tag;
        end else if (i_ctrl.ins) begin
            if (i_left_prefix) begin
                r_seq <= i_left_seq;
                r_len <= i_left_len;
                r_tag <= i_left_tag;
            end else if (w_hit || w_slot_free) begin
                r_seq <= i_new_seq;
                r_len <= i_new_len;
                r_tag <= i_new_tag;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_seq   = r_seq;
    assign o_len   = r_len;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

[rtl/out_of_order_segment_reassembly.sv]
// Top level: sorted chain of oosr_cell slots, drain sequencer and output register.
// Depends on oosr_pkg, oosr_cell and out_of_order_segment_reassembly_assert.svh.
//
// Channel  | Dir | Handshake            | Payload
// s        | in  | i_s_tvalid/o_s_tready | seq, length, tag, free bytes
// m        | out | o_m_tvalid/i_m_tready | kind (tuser), segment/status (tdata), tlast
// cfg      | in  | i_cfg_we             | initial expected sequence
//
// A segment is inserted into the chain in its accept cycle unless the chain
// is full; the drain then releases matching entries one at a time through the
// single head-release port of the chain and ends with one status beat. The
// output register stalls the drain while a beat is not taken. Reset is
// synchronous and clears the chain.
`default_nettype none
`include "out_of_order_segment_reassembly_assert.svh"

module out_of_order_segment_reassembly #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned TAG_BITS    = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [31:0]  i_cfg_wdata,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // seg_seq[31:0], seg_length, payload_tag, ring_free_bytes, zero fill
    input  wire  [((64+TAG_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // out_seq[31:0], out_length, out_tag, drain_status, next_expected, zero fill
    output logic [((83+TAG_BITS+7)/8)*8-1:0] o_m_tdata,
    // item_kind
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast
);

    localparam int unsigned SB = oosr_pkg::SEQ_BITS;
    localparam int unsigned LB = oosr_pkg::LEN_BITS;
    localparam int unsigned RB = oosr_pkg::ROOM_BITS;
    localparam int unsigned OUT_W = ((83 + TAG_BITS + 7) / 8) * 8;

    logic [SB-1:0]       w_in_seq;
    logic [LB-1:0]       w_in_len;
    logic [TAG_BITS-1:0] w_in_tag;
    logic [RB-1:0]       w_in_room;

    assign w_in_seq  = i_s_tdata[SB-1:0];
    assign w_in_len  = i_s_tdata[SB+LB-1:SB];
    assign w_in_tag  = i_s_tdata[SB+LB+TAG_BITS-1:SB+LB];
    assign w_in_room = i_s_tdata[SB+LB+TAG_BITS+RB-1:SB+LB+TAG_BITS];

    oosr_pkg::t_state     r_state, n_state;
    logic [SB-1:0]        r_exp;
    logic [RB-1:0]        r_room;
    logic                 r_drop;

    logic                 r_m_valid;
    oosr_pkg::t_kind      r_m_kind;
    logic [SB-1:0]        r_m_seq;
    logic [LB-1:0]        r_m_len;
    logic [TAG_BITS-1:0]  r_m_tag;
    oosr_pkg::t_status    r_m_status;
    logic [SB-1:0]        r_m_next;
    logic                 r_m_last;

    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_prefix;
    logic [SB-1:0]          w_seq [TABLE_DEPTH];
    logic [LB-1:0]          w_len [TABLE_DEPTH];
    logic [TAG_BITS-1:0]    w_tag [TABLE_DEPTH];

    logic                 w_accept;
    logic                 w_full;
    logic                 w_out_free;
    logic                 w_release;
    logic                 w_finish;
    logic                 w_match;
    oosr_pkg::t_status    w_status;
    oosr_pkg::t_cell_ctrl w_ctrl;
    logic [SB-1:0]        w_exp_after;

    assign w_full     = w_valid[TABLE_DEPTH-1];
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_match    = w_valid[0] && (w_seq[0] == r_exp);
    assign w_exp_after = r_exp + SB'(w_len[0]);

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic                l_valid;
            logic                l_prefix;
            logic [SB-1:0]       l_seq;
            logic [LB-1:0]       l_len;
            logic [TAG_BITS-1:0] l_tag;
            logic                r_valid_in;
            logic [SB-1:0]       r_seq_in;
            logic [LB-1:0]       r_len_in;
            logic [TAG_BITS-1:0] r_tag_in;

            if (g == 0) begin : g_first
                assign l_valid  = 1'b1;
                assign l_prefix = 1'b0;
                assign l_seq    = w_in_seq;
                assign l_len    = w_in_len;
                assign l_tag    = w_in_tag;
            end else begin : g_mid
                assign l_valid  = w_valid[g-1];
                assign l_prefix = w_prefix[g-1];
                assign l_seq    = w_seq[g-1];
                assign l_len    = w_len[g-1];
                assign l_tag    = w_tag[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_last
                assign r_valid_in = 1'b0;
                assign r_seq_in   = '0;
                assign r_len_in   = '0;
                assign r_tag_in   = '0;
            end else begin : g_inner
                assign r_valid_in = w_valid[g+1];
                assign r_seq_in   = w_seq[g+1];
                assign r_len_in   = w_len[g+1];
                assign r_tag_in   = w_tag[g+1];
            end

            oosr_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_seq     (w_in_seq),
                .i_new_len     (w_in_len),
                .i_new_tag     (w_in_tag),
                .i_left_valid  (l_valid),
                .i_left_prefix (l_prefix),
                .i_left_seq    (l_seq),
                .i_left_len    (l_len),
                .i_left_tag    (l_tag),
                .i_right_valid (r_valid_in),
                .i_right_seq   (r_seq_in),
                .i_right_len   (r_len_in),
                .i_right_tag   (r_tag_in),
                .o_valid       (w_valid[g]),
                .o_prefix      (w_prefix[g]),
                .o_seq         (w_seq[g]),
                .o_len         (w_len[g]),
                .o_tag         (w_tag[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oosr_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = oosr_pkg::S_DRAIN;
                end
            end
            oosr_pkg::S_DRAIN: begin
                if (w_finish) begin
                    n_state = oosr_pkg::S_IDLE;
                end
            end
            default: n_state = oosr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_release  = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            oosr_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            oosr_pkg::S_DRAIN: begin
                w_release = w_out_free && w_match && (w_len[0] <= r_room);
                w_finish  = w_out_free && !w_release;
            end
            default: ;
        endcase
        w_ctrl.ins = w_accept && !w_full;
        w_ctrl.pop = w_release;
    end

    always_comb begin
        priority if (r_drop) begin
            w_status = oosr_pkg::ST_DROPPED;
        end else if (!w_valid[0]) begin
            w_status = oosr_pkg::ST_EMPTY;
        end else if (w_match) begin
            w_status = oosr_pkg::ST_BUF_FULL;
        end else if (oosr_pkg::seq_before(r_exp, w_seq[0])) begin
            w_status = oosr_pkg::ST_GAP;
        end else begin
            w_status = oosr_pkg::ST_STALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= oosr_pkg::S_IDLE;
            r_exp     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end else if (w_release) begin
                r_exp <= w_exp_after;
            end
            if (w_release || w_finish) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_room <= w_in_room;
            r_drop <= w_full;
        end else if (w_release) begin
            r_room <= r_room - w_len[0];
        end
        if (w_release) begin
            r_m_kind   <= oosr_pkg::KIND_RELEASE;
            r_m_seq    <= w_seq[0];
            r_m_len    <= w_len[0];
            r_m_tag    <= w_tag[0];
            r_m_status <= oosr_pkg::ST_EMPTY;
            r_m_next   <= w_exp_after;
            r_m_last   <= 1'b0;
        end else if (w_finish) begin
            r_m_kind   <= oosr_pkg::KIND_STATUS;
            r_m_seq    <= '0;
            r_m_len    <= '0;
            r_m_tag    <= '0;
            r_m_status <= w_status;
            r_m_next   <= r_exp;
            r_m_last   <= 1'b1;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tuser[0] = r_m_kind;
    assign o_m_tlast    = r_m_last;
    assign o_m_tdata    = OUT_W'({r_m_next, r_m_status, r_m_tag, r_m_len, r_m_seq});

    logic [TABLE_DEPTH-1:0] w_valid_inc;
    logic [TABLE_DEPTH-1:0] w_valid_grow;
    assign w_valid_inc  = w_valid + TABLE_DEPTH'(1);
    assign w_valid_grow = {w_valid[TABLE_DEPTH-2:0], 1'b1};

    `OOSR_ASSERT_SAME(a_chain_packed, i_clk, i_rst_n, 1'b1, (w_valid & w_valid_inc) == '0)
    `OOSR_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, w_accept && w_full, $stable(w_valid))
    `OOSR_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctrl.ins, w_valid == $past(w_valid_grow))
    `OOSR_ASSERT_NEXT(a_release_beat, i_clk, i_rst_n, w_release, o_m_tvalid && !o_m_tlast)

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for out_of_order_segment_reassembly: directed segment cases, then
// random segment flows under sender idle and receiver stall patterns, checked by a local model.
// Depends on oosr_pkg and the RTL of the block.
module tb_top;

    localparam int unsigned SLOTS         = 16;
    localparam int unsigned TAG_W         = 8;
    localparam int unsigned S_W           = ((64 + TAG_W + 7) / 8) * 8;
    localparam int unsigned M_W           = ((83 + TAG_W + 7) / 8) * 8;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned FLOW_ITEMS    = 100;
    localparam logic [15:0] ROOM_MAX      = 16'hFFFF;

    typedef struct {
        oosr_pkg::t_kind   kind;
        logic [31:0]       seq;
        logic [15:0]       len;
        logic [TAG_W-1:0]  tag;
        oosr_pkg::t_status status;
        logic [31:0]       next;
        logic              tlast;
    } t_drain_beat;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [31:0]      i_cfg_wdata = '0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    // seg_seq, seg_length, payload_tag, ring_free_bytes
    logic [S_W-1:0]   i_s_tdata   = '0;
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    // out_seq, out_length, out_tag, drain_status, next_expected
    logic [M_W-1:0]   o_m_tdata;
    // item_kind
    logic [0:0]       o_m_tuser;
    logic             o_m_tlast;

    logic [31:0]      tbl_seq [SLOTS];
    logic [15:0]      tbl_len [SLOTS];
    logic [TAG_W-1:0] tbl_tag [SLOTS];
    int               tbl_count = 0;
    logic [31:0]      rcv_next  = '0;

    t_drain_beat      drain_beats_q [$];
    int unsigned      fail_count     = 0;
    int unsigned      items_sent     = 0;
    int unsigned      quiet_cycles   = 0;
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;

    out_of_order_segment_reassembly #(
        .TABLE_DEPTH (SLOTS),
        .TAG_BITS    (TAG_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit seq_precedes(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic void reassemble_segment(input logic [31:0] seq, input logic [15:0] len,
                                               input logic [TAG_W-1:0] tag,
                                               input logic [15:0] room);
        int                pos;
        int unsigned       room_left;
        bit                dropped;
        bit                draining;
        oosr_pkg::t_status st;
        t_drain_beat       beat;
        room_left = 32'(room);
        dropped = (tbl_count >= SLOTS);
        if (!dropped) begin
            pos = tbl_count;
            for (int i = 0; i < tbl_count; i++) begin
                if (pos == tbl_count && seq_precedes(seq, tbl_seq[i])) begin
                    pos = i;
                end
            end
            for (int i = tbl_count; i > pos; i--) begin
                tbl_seq[i] = tbl_seq[i-1];
                tbl_len[i] = tbl_len[i-1];
                tbl_tag[i] = tbl_tag[i-1];
            end
            tbl_seq[pos] = seq;
            tbl_len[pos] = len;
            tbl_tag[pos] = tag;
            tbl_count++;
        end
        st = oosr_pkg::ST_EMPTY;
        draining = 1'b1;
        while (draining) begin
            if (tbl_count == 0) begin
                st = oosr_pkg::ST_EMPTY;
                draining = 1'b0;
            end else if (tbl_seq[0] == rcv_next) begin
                if (32'(tbl_len[0]) > room_left) begin
                    st = oosr_pkg::ST_BUF_FULL;
                    draining = 1'b0;
                end else begin
                    room_left -= 32'(tbl_len[0]);
                    rcv_next += 32'(tbl_len[0]);
                    beat = '{oosr_pkg::KIND_RELEASE, tbl_seq[0], tbl_len[0], tbl_tag[0],
                             oosr_pkg::ST_EMPTY, rcv_next, 1'b0};
                    drain_beats_q.push_back(beat);
                    for (int i = 1; i < tbl_count; i++) begin
                        tbl_seq[i-1] = tbl_seq[i];
                        tbl_len[i-1] = tbl_len[i];
                        tbl_tag[i-1] = tbl_tag[i];
                    end
                    tbl_count--;
                end
            end else begin
                st = seq_precedes(rcv_next, tbl_seq[0]) ? oosr_pkg::ST_GAP : oosr_pkg::ST_STALE;
                draining = 1'b0;
            end
        end
        if (dropped) begin
            st = oosr_pkg::ST_DROPPED;
        end
        beat = '{oosr_pkg::KIND_STATUS, '0, '0, '0, st, rcv_next, 1'b1};
        drain_beats_q.push_back(beat);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_drain_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drain_beats_q.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual tdata=%h tuser=%b tlast=%b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
                fail_count++;
            end else begin
                want = drain_beats_q.pop_front();
                check_field("item_kind", 32'(want.kind), 32'(o_m_tuser[0]));
                check_field("out_seq", want.seq, o_m_tdata[31:0]);
                check_field("out_length", 32'(want.len), 32'(o_m_tdata[47:32]));
                check_field("out_tag", 32'(want.tag), 32'(o_m_tdata[48 +: TAG_W]));
                check_field("drain_status", 32'(want.status), 32'(o_m_tdata[48+TAG_W +: 3]));
                check_field("next_expected", want.next, o_m_tdata[51+TAG_W +: 32]);
                check_field("last", 32'(want.tlast), 32'(o_m_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
        begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_segment(input logic [31:0] seq, input logic [15:0] len,
                                input logic [TAG_W-1:0] tag, input logic [15:0] room);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {room, tag, len, seq};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        reassemble_segment(seq, len, tag, room);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drain the block, then load the expected sequence.
    task automatic load_expected(input logic [31:0] value);
        i_s_tvalid <= 1'b0;
        wait (drain_beats_q.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rcv_next = value;
    endtask

    // Empty the table by pointing the expected sequence at, or just before, the head entry.
    task automatic clear_table();
        int guard;
        guard = 0;
        while (tbl_count != 0 && guard < 4 * SLOTS) begin
            guard++;
            if (tbl_count == SLOTS) begin
                load_expected(tbl_seq[0]);
                push_segment(tbl_seq[0] + 32'h1000, 16'd1, TAG_W'($urandom), ROOM_MAX);
            end else if (tbl_len[0] == ROOM_MAX) begin
                load_expected(tbl_seq[0]);
                push_segment(tbl_seq[0] + 32'hFFFF, 16'd0, TAG_W'($urandom), ROOM_MAX);
            end else begin
                load_expected(tbl_seq[0] - 1);
                push_segment(tbl_seq[0] - 1, 16'd1, TAG_W'($urandom), ROOM_MAX);
            end
        end
    endtask

    task automatic test_reset_state_zero_length();
        push_segment(32'd0, 16'd0, 8'h00, 16'd0);
    endtask

    task automatic test_buffer_full();
        push_segment(32'd0, 16'd10, 8'h11, 16'd5);
        push_segment(32'd10, 16'd20, 8'h22, ROOM_MAX);
    endtask

    task automatic test_gap();
        push_segment(32'd100, 16'd5, 8'h33, ROOM_MAX);
        push_segment(32'd30, 16'd70, 8'h44, ROOM_MAX);
    endtask

    task automatic test_stale_head();
        push_segment(32'd50, 16'd3, 8'h55, ROOM_MAX);
        clear_table();
    endtask

    task automatic test_wrap_order();
        load_expected(32'hFFFF_FFF0);
        push_segment(32'h0000_0005, 16'd3, 8'h66, ROOM_MAX);
        push_segment(32'hFFFF_FFF0, 16'h15, 8'h77, ROOM_MAX);
    endtask

    task automatic test_equal_seq_order();
        logic [31:0] base;
        base = rcv_next;
        push_segment(base + 10, 16'd0, 8'hA1, ROOM_MAX);
        push_segment(base + 10, 16'd5, 8'hB2, ROOM_MAX);
        push_segment(base, 16'd10, 8'hC3, ROOM_MAX);
    endtask

    task automatic test_table_full_drop();
        load_expected(32'h8000_0000);
        for (int i = 0; i < SLOTS; i++) begin
            push_segment(32'h8000_0010 + i * 16, 16'd16, TAG_W'(i), ROOM_MAX);
        end
        push_segment(32'h8000_0000, 16'd16, 8'hA5, ROOM_MAX);
        clear_table();
    endtask

    task automatic test_field_extremes();
        load_expected(32'hFFFF_FFFF);
        push_segment(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, ROOM_MAX);
        push_segment(rcv_next, 16'd1, 8'h00, 16'd0);
        clear_table();
        load_expected(32'h0000_0000);
    endtask

    task automatic run_flow();
        logic [31:0]      seg_seq [SLOTS];
        logic [15:0]      seg_len [SLOTS];
        logic [TAG_W-1:0] seg_tag [SLOTS];
        logic [31:0]      base;
        logic [31:0]      hold_seq;
        logic [15:0]      hold_len;
        logic [TAG_W-1:0] hold_tag;
        logic [15:0]      room;
        int               n;
        int               j;
        int               r;
        clear_table();
        r = $urandom_range(0, 7);
        case (r)
            0: load_expected(32'h0000_0000);
            1: load_expected(32'hFFFF_FFFF);
            2: load_expected(32'hFFFF_FFFF - $urandom_range(0, 4000));
            3: load_expected(32'h7FFF_FFFF - $urandom_range(0, 4000));
            4, 5: load_expected($urandom);
            default: ;
        endcase
        base = rcv_next;
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                seg_len[i] = '0;
            end else if (r < 15) begin
                seg_len[i] = 16'($urandom_range(1, 1500));
            end else if (r < 17) begin
                seg_len[i] = 16'($urandom_range(1500, 65534));
            end else begin
                seg_len[i] = 16'($urandom_range(1, 64));
            end
            seg_seq[i] = base;
            seg_tag[i] = TAG_W'($urandom);
            base += 32'(seg_len[i]);
        end
        if ($urandom_range(0, 2) != 0) begin
            for (int i = n - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                hold_seq = seg_seq[i];
                hold_len = seg_len[i];
                hold_tag = seg_tag[i];
                seg_seq[i] = seg_seq[j];
                seg_len[i] = seg_len[j];
                seg_tag[i] = seg_tag[j];
                seg_seq[j] = hold_seq;
                seg_len[j] = hold_len;
                seg_tag[j] = hold_tag;
            end
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                room = ROOM_MAX;
            end else if (r < 8) begin
                room = 16'($urandom);
            end else begin
                room = 16'($urandom_range(0, 3000));
            end
            push_segment(seg_seq[i], seg_len[i], seg_tag[i], room);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_segment($urandom, 16'($urandom), TAG_W'($urandom), 16'($urandom));
            end else if (r < 12) begin
                j = $urandom_range(0, i);
                push_segment(seg_seq[j], seg_len[j], seg_tag[j], 16'($urandom));
            end
        end
    endtask

    task automatic test_random_flows();
        int unsigned idle_pct  [4] = '{0, 47, 0, 29};
        int unsigned stall_pct [4] = '{0, 0, 47, 29};
        int unsigned start;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            start = items_sent;
            while (items_sent - start < FLOW_ITEMS) begin
                run_flow();
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state_zero_length();
        test_buffer_full();
        test_gap();
        test_stale_head();
        test_wrap_order();
        test_equal_seq_order();
        test_table_full_drop();
        test_field_extremes();
        test_random_flows();
        i_s_tvalid <= 1'b0;
        wait (drain_beats_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
